FILE: hdl/sqe_pkg.sv
// Shared types and constants for the stack/queue engine.
// No dependencies; imported by every module of the block.
package sqe_pkg;

    localparam int DATA_W    = 32;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 7;
    localparam int DEPTH_DEF = 64;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((ACTION_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + 1 + DATA_W + FILL_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_SWAP = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_SWAP_SHORT = 2'd2,
        ST_PUSH_FULL  = 2'd3
    } status_t;

    // what every cell of the row does when the row updates
    typedef enum logic [2:0] {
        CELL_HOLD     = 3'd0,
        CELL_SHIFT_DN = 3'd1,
        CELL_SHIFT_UP = 3'd2,
        CELL_SWAP     = 3'd3,
        CELL_APPEND   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [DATA_W-1:0]   value;
    } cell_cmd_t;

endpackage

FILE: hdl/sqe_cell.sv
// One storage cell of the stack/queue row; cell 0 holds the top entry.
// Depends on sqe_pkg for the command struct.
module sqe_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                               aclk,
    input  sqe_pkg::cell_cmd_t                 cmd,
    input  logic [CNT_W-1:0]                   wr_idx,
    input  logic signed [sqe_pkg::DATA_W-1:0]  above,
    input  logic signed [sqe_pkg::DATA_W-1:0]  below,
    output logic signed [sqe_pkg::DATA_W-1:0]  entry
);
    import sqe_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_SHIFT_DN: entry_next = (IDX == 0) ? cmd.value : above;
            CELL_SHIFT_UP: entry_next = below;
            CELL_SWAP: begin
                if (IDX == 0) begin
                    entry_next = below;
                end else if (IDX == 1) begin
                    entry_next = above;
                end
            end
            CELL_APPEND: begin
                if (wr_idx == CNT_W'(IDX)) begin
                    entry_next = cmd.value;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: hdl/stack_queue_engine_top.sv
// Stack/queue engine: a row of DEPTH cells that shift as a unit, plus control.
// Each accepted item's result is registered and shown on the m_ side in the next cycle.
// Throughput: one item per cycle unless the m_ side stalls; the whole row updates in the accept cycle.
// s_tready drops only while a result waits and m_tready is low.
// Reset (aresetn low, synchronous): depth 0, stack mode, output slot empty;
// cell contents are not cleared.
module stack_queue_engine_top #(
    parameter int DEPTH = sqe_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,    // queue_mode
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] action, [33:2] push_value
    input  logic [sqe_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [2] top_valid, [34:3] top_value, [41:35] fill_count
    output logic [sqe_pkg::M_TDATA_W-1:0]   m_tdata
);
    import sqe_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     mode_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  status_reg, status_next;
    logic                     tvalid_reg, tvalid_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;

    logic                     acc;
    action_t                  action;
    logic signed [DATA_W-1:0] push_value;
    logic signed [DATA_W-1:0] top_after;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] cell_q [DEPTH];

    assign cfg_ready  = 1'b1;
    assign s_tready   = !m_valid_reg || m_tready;
    assign acc        = s_tvalid && s_tready;
    assign action     = action_t'(s_tdata[ACTION_W-1:0]);
    assign push_value = s_tdata[ACTION_W +: DATA_W];

    always_comb begin
        cmd.op      = CELL_HOLD;
        cmd.value   = push_value;
        count_next  = count_reg;
        status_next = ST_OK;
        top_after   = cell_q[0];
        unique case (action)
            ACT_PUSH: begin
                if (count_reg == CNT_W'(DEPTH)) begin
                    status_next = ST_PUSH_FULL;
                end else if (!mode_reg || count_reg == '0) begin
                    cmd.op     = CELL_SHIFT_DN;
                    count_next = count_reg + 1'b1;
                    top_after  = push_value;
                end else begin
                    // queue mode: land below the deepest entry
                    cmd.op     = CELL_APPEND;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_POP_EMPTY;
                end else begin
                    cmd.op     = CELL_SHIFT_UP;
                    count_next = count_reg - 1'b1;
                    top_after  = cell_q[1];
                end
            end
            ACT_SWAP: begin
                if (count_reg < CNT_W'(2)) begin
                    status_next = ST_SWAP_SHORT;
                end else begin
                    cmd.op    = CELL_SWAP;
                    top_after = cell_q[1];
                end
            end
            ACT_NOP: begin
                cmd.op = CELL_HOLD;
            end
            default: cmd.op = CELL_HOLD;
        endcase
        if (!acc) begin
            cmd.op     = CELL_HOLD;
            count_next = count_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [DATA_W-1:0] above_d;
            logic signed [DATA_W-1:0] below_d;
            if (gi == 0) begin : g_first
                assign above_d = '0;
            end else begin : g_mid_a
                assign above_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign below_d = '0;
            end else begin : g_mid_b
                assign below_d = cell_q[gi+1];
            end
            sqe_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk   (aclk),
                .cmd    (cmd),
                .wr_idx (count_reg),
                .above  (above_d),
                .below  (below_d),
                .entry  (cell_q[gi])
            );
        end
    endgenerate

    assign tvalid_next  = (count_next != '0);
    assign value_next   = tvalid_next ? top_after : '0;
    assign fill_next    = FILL_W'(count_next);
    assign m_valid_next = acc ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            status_reg <= status_next;
            tvalid_reg <= tvalid_next;
            value_reg  <= value_next;
            fill_reg   <= fill_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({fill_reg, value_reg, tvalid_reg, status_reg});

endmodule

FILE: hdl/sqe_checker.sv
// Port-level checks for the stack/queue engine, bound to the top level.
// Depends on sqe_pkg for payload widths.
module sqe_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sqe_pkg::M_TDATA_W-1:0]  m_tdata
);
    import sqe_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every accepted item shows its result the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted item");

    // an empty output slot never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output slot");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stack_queue_engine_top sqe_checker u_sqe_checker (.*);

FILE: dv/tb.sv
// Self-checking testbench for stack_queue_engine_top: stack and queue traffic
// on the item streams, checked against an in-bench ring model of the store.
// Depends on sqe_pkg (hdl/sqe_pkg.sv) and the engine RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sqe_pkg::*;

    localparam int RING        = DEPTH_DEF;
    localparam int QUIET_LIMIT = 500;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [FILL_W-1:0]        fill_count;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        status_t                  status;
    } outcome_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;   // queue_mode
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;     // [1:0] action, [33:2] push_value
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [1:0] status, [2] top_valid, [34:3] top_value, [41:35] fill_count
    logic [M_TDATA_W-1:0] m_tdata;

    // ring model of the store
    logic signed [DATA_W-1:0] ring_mem [RING];
    int unsigned              head_idx  = 0;
    int unsigned              held      = 0;
    bit                       fifo_mode = 1'b0;

    outcome_t expected_outputs [$];
    int       errors       = 0;
    bit       idle_on      = 1'b1;
    int       stall_left   = 0;
    int       quiet_cycles = 0;

    stack_queue_engine_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic outcome_t predict_after_op(action_t act, logic signed [DATA_W-1:0] val);
        outcome_t                 res;
        logic signed [DATA_W-1:0] tmp;
        int unsigned              second;
        res.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (held >= RING) begin
                    res.status = ST_PUSH_FULL;
                end else if (held == 0 || !fifo_mode) begin
                    if (held != 0) begin
                        head_idx = (head_idx == 0) ? RING - 1 : head_idx - 1;
                    end
                    ring_mem[head_idx] = val;
                    held++;
                end else begin
                    // queue mode: goes below the deepest entry
                    ring_mem[(head_idx + held) % RING] = val;
                    held++;
                end
            end
            ACT_POP: begin
                if (held == 0) begin
                    res.status = ST_POP_EMPTY;
                end else begin
                    held--;
                    if (held != 0) begin
                        head_idx = (head_idx + 1) % RING;
                    end
                end
            end
            ACT_SWAP: begin
                if (held < 2) begin
                    res.status = ST_SWAP_SHORT;
                end else begin
                    second = (head_idx + 1) % RING;
                    tmp = ring_mem[head_idx];
                    ring_mem[head_idx] = ring_mem[second];
                    ring_mem[second] = tmp;
                end
            end
            default: ;
        endcase
        res.top_valid  = (held != 0);
        res.top_value  = (held != 0) ? ring_mem[head_idx] : '0;
        res.fill_count = held[FILL_W-1:0];
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic action_t pick_action(int push_pct, int pop_pct, int swap_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return ACT_PUSH;
        if (r < push_pct + pop_pct) return ACT_POP;
        if (r < push_pct + pop_pct + swap_pct) return ACT_SWAP;
        return ACT_NOP;
    endfunction

    task automatic send_item(action_t act, logic signed [DATA_W-1:0] val);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, act});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_outputs.push_back(predict_after_op(act, val));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_mode(bit mode);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        fifo_mode = mode;
    endtask

    // empty-store errors, value extremes, swap and the no-op code in stack mode
    task automatic test_directed_stack();
        send_item(ACT_POP, 32'sh0);
        send_item(ACT_SWAP, 32'sh0);
        send_item(ACT_NOP, 32'shffffffff);
        send_item(ACT_PUSH, 32'sh7fffffff);
        send_item(ACT_SWAP, 32'sh12345678);
        send_item(ACT_PUSH, 32'sh80000000);
        send_item(ACT_SWAP, 32'sh0);
        send_item(ACT_NOP, 32'sh5a5a5a5a);
        send_item(ACT_PUSH, 32'sh0);
        send_item(ACT_PUSH, 32'shffffffff);
        send_item(ACT_POP, 32'shffffffff);
        send_item(ACT_POP, 32'sh0);
    endtask

    // switch to queue mode with entries still held
    task automatic test_directed_queue();
        write_mode(1'b1);
        send_item(ACT_PUSH, 32'sh00001234);
        send_item(ACT_PUSH, 32'sh5555aaaa);
        send_item(ACT_SWAP, 32'sh0);
        send_item(ACT_NOP, 32'sh0);
        send_item(ACT_POP, 32'sh0);
        send_item(ACT_POP, 32'sh0);
        send_item(ACT_POP, 32'sh0);
        send_item(ACT_POP, 32'sh0);
        send_item(ACT_POP, 32'sh0);
    endtask

    task automatic test_fill_drain(bit mode);
        write_mode(mode);
        while (held < RING) begin
            send_item(($urandom_range(0, 9) == 0) ? ACT_SWAP : ACT_PUSH, pick_value());
        end
        repeat (3) send_item(ACT_PUSH, pick_value());
        send_item(ACT_SWAP, pick_value());
        while (held > 0) begin
            send_item(($urandom_range(0, 9) == 0) ? ACT_SWAP : ACT_POP, pick_value());
        end
        repeat (2) send_item(ACT_POP, pick_value());
    endtask

    task automatic test_random_traffic();
        int push_pct;
        int pop_pct;
        for (int phase = 0; phase < 11; phase++) begin
            idle_on = (phase != 10);
            write_mode(phase == 0 ? 1'b1 : (phase == 1 ? 1'b0 : 1'($urandom_range(0, 1))));
            case (phase % 3)
                0: begin
                    push_pct = 40;
                    pop_pct  = 35;
                end
                1: begin
                    push_pct = 65;
                    pop_pct  = 20;
                end
                default: begin
                    push_pct = 25;
                    pop_pct  = 55;
                end
            endcase
            repeat (145) send_item(pick_action(push_pct, pop_pct, 12), pick_value());
        end
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_tready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 18);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            errors++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
            if (expected_outputs.size() == 0) begin
                errors++;
                $error("result with no item pending: m_tdata %h", m_tdata);
            end else begin
                want = expected_outputs.pop_front();
                compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
                compare_field("top_valid", DATA_W'(want.top_valid), DATA_W'(got.top_valid));
                compare_field("top_value", want.top_value, got.top_value);
                compare_field("fill_count", DATA_W'(want.fill_count), DATA_W'(got.fill_count));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_stack();
        test_directed_queue();
        test_fill_drain(1'b0);
        test_fill_drain(1'b1);
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sqe_pkg.sv
hdl/sqe_cell.sv
hdl/stack_queue_engine_top.sv
hdl/sqe_checker.sv
dv/tb.sv
